// File: hw/rtl/slot_table_with_holes_top_macros.svh
// Assertion macros for the slot table checker.
// No dependencies; included by the checker file only.
`ifndef SLOT_TABLE_WITH_HOLES_TOP_MACROS_SVH
`define SLOT_TABLE_WITH_HOLES_TOP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define STH_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define STH_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sth_pkg.sv
// Shared types and constants for the slot table with holes.
// No dependencies.
package sth_pkg;

  localparam int HANDLE_W = 64;
  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 7;
  localparam int IOUT_W   = 6;
  localparam int USED_W   = 7;
  localparam int CAP_W    = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 3'd0,
    FN_SET      = 3'd1,
    FN_REM_IDX  = 3'd2,
    FN_REM_VAL  = 3'd3,
    FN_GET      = 3'd4,
    FN_POP      = 3'd5,
    FN_PEEK     = 3'd6,
    FN_INDEX_OF = 3'd7
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_REMOVE,
    ST_READ,
    ST_TRIM_RD,
    ST_TRIM_CK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] handle_out;
    logic [IOUT_W-1:0]   index_out;
    logic [USED_W-1:0]   used_out;
  } res_t;

endpackage

// File: hw/rtl/slot_table_with_holes_top.sv
// Top level of the slot table with holes.
// Depends on sth_pkg, sth_mem, sth_ctrl and sth_oreg.
//
// Usage: one operation per input transfer on in_valid/in_ready (func, handle,
// slot_index); one result per operation on out_valid/out_ready (status,
// handle_out, index_out, used_out). The capacity register must be written
// with cfg_we/cfg_data only while the block is idle; it is not enforced.
// Set, append and an add on an unfragmented table go from EXEC straight to
// DONE; get and peek pass through READ, and remove by index through REMOVE.
// Add while fragmented, remove by value and index-of scan the used
// slots at one memory read per cycle. Removing or popping the last slot
// then trims trailing empty slots one at a time, as each trim step waits
// on the registered read of the slot memory.
// Items are handled one at a time; the next input is taken once the result
// has moved into the output register.
// Reset clears the used count, the fragmented flag and the capacity (to 64);
// slot contents are not cleared. When the receiver stalls, one result waits
// in the output register while the next item is processed, and the block
// then holds that item's result until the register frees.
module slot_table_with_holes_top
  import sth_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [IDX_W-1:0]    slot_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [IOUT_W-1:0]   index_out,
  output logic [USED_W-1:0]   used_out
);

  localparam int AW = $clog2(SLOTS);

  logic                res_valid, res_ready;
  res_t                res, out_res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [HANDLE_W-1:0] mem_wdata, mem_rdata;

  sth_mem #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .DW    (HANDLE_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sth_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .handle     (handle),
    .slot_index (slot_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sth_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status     = out_res.status;
  assign handle_out = out_res.handle_out;
  assign index_out  = out_res.index_out;
  assign used_out   = out_res.used_out;

endmodule

// File: hw/rtl/sth_mem.sv
// Slot storage: one write port and one registered read port.
// No package dependencies; a write to the address being read is forwarded.
module sth_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sth_ctrl.sv
// Operation sequencer: decodes one item, scans and updates the slot memory.
// Depends on sth_pkg; drives the ports of sth_mem.
module sth_ctrl
  import sth_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [IDX_W-1:0]    slot_index,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [HANDLE_W-1:0] mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [HANDLE_W-1:0] mem_rdata
);

  localparam int UW = $clog2(SLOTS + 1);
  localparam int XW = (UW > CAP_W) ? UW : CAP_W;

  state_t              state, state_next;
  logic [CAP_W-1:0]    cap;
  logic [UW-1:0]       used, used_next;
  logic                frag, frag_next;
  func_t               func_q, func_q_next;
  logic [HANDLE_W-1:0] handle_q, handle_q_next;
  logic [IDX_W-1:0]    idx_q, idx_q_next;
  logic [UW-1:0]       ptr, ptr_next;
  logic [AW-1:0]       chk, chk_next;
  logic                pend, pend_next;
  logic [AW-1:0]       tgt, tgt_next;
  logic                ok, ok_next;
  logic [HANDLE_W-1:0] hout, hout_next;
  logic [IOUT_W-1:0]   iout, iout_next;

  logic [UW-1:0]       used_m1;
  logic [XW-1:0]       eff_cap;
  logic                can_app, app_req;
  logic                idx_gt_used, idx_eq_used, idx_ge_used;
  logic                used_zero, ptr_lt_used, tgt_is_last;
  logic [HANDLE_W-1:0] key;
  logic                found, rd_zero;

  assign used_m1     = used - UW'(1);
  assign eff_cap     = (XW'(cap) > XW'(SLOTS)) ? XW'(SLOTS) : XW'(cap);
  assign can_app     = XW'(used) < eff_cap;
  assign idx_gt_used = XW'(idx_q) > XW'(used);
  assign idx_eq_used = XW'(idx_q) == XW'(used);
  assign idx_ge_used = idx_gt_used || idx_eq_used;
  assign used_zero   = (used == '0);
  assign ptr_lt_used = ptr < used;
  assign tgt_is_last = UW'(tgt) == used_m1;
  assign key         = (func_q == FN_ADD) ? '0 : handle_q;
  assign found       = pend && (mem_rdata == key);
  assign rd_zero     = (mem_rdata == '0);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = '{status: !ok, handle_out: hout, index_out: iout,
                       used_out: USED_W'(used)};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (func_q)
          FN_ADD:      state_next = frag ? ST_SCAN : ST_DONE;
          FN_SET:      state_next = ST_DONE;
          FN_REM_IDX:  state_next = idx_ge_used ? ST_DONE : ST_REMOVE;
          FN_REM_VAL:  state_next = ST_SCAN;
          FN_GET:      state_next = idx_ge_used ? ST_DONE : ST_READ;
          FN_POP:      state_next = used_zero ? ST_DONE : ST_READ;
          FN_PEEK:     state_next = used_zero ? ST_DONE : ST_READ;
          FN_INDEX_OF: state_next = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        priority if (found) begin
          state_next = (func_q == FN_REM_VAL) ? ST_REMOVE : ST_DONE;
        end else if (ptr_lt_used) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_REMOVE:  state_next = tgt_is_last ? ST_TRIM_RD : ST_DONE;
      ST_READ:    state_next = (func_q == FN_POP) ? ST_TRIM_RD : ST_DONE;
      ST_TRIM_RD: state_next = used_zero ? ST_DONE : ST_TRIM_CK;
      ST_TRIM_CK: state_next = rd_zero ? ST_TRIM_RD : ST_DONE;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    used_next     = used;
    frag_next     = frag;
    func_q_next   = func_q;
    handle_q_next = handle_q;
    idx_q_next    = idx_q;
    ptr_next      = ptr;
    chk_next      = chk;
    pend_next     = pend;
    tgt_next      = tgt;
    ok_next       = ok;
    hout_next     = hout;
    iout_next     = iout;
    mem_we        = 1'b0;
    mem_waddr     = tgt;
    mem_wdata     = '0;
    mem_raddr     = '0;
    app_req       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        func_q_next   = func_t'(func);
        handle_q_next = handle;
        idx_q_next    = slot_index;
        ok_next       = 1'b0;
        hout_next     = '0;
        iout_next     = '0;
      end
      ST_EXEC: begin
        ptr_next  = '0;
        pend_next = 1'b0;
        unique case (func_q)
          FN_ADD: begin
            if (!frag) app_req = 1'b1;
          end
          FN_SET: begin
            priority if (idx_eq_used) begin
              app_req = 1'b1;
            end else if (!idx_gt_used) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(idx_q);
              mem_wdata = handle_q;
              ok_next   = 1'b1;
            end else begin
              ok_next = 1'b0;
            end
          end
          FN_REM_IDX:  tgt_next  = AW'(idx_q);
          FN_REM_VAL:  pend_next = 1'b0;
          FN_GET:      mem_raddr = AW'(idx_q);
          FN_POP:      mem_raddr = AW'(used_m1);
          FN_PEEK:     mem_raddr = AW'(used_m1);
          FN_INDEX_OF: pend_next = 1'b0;
        endcase
      end
      ST_SCAN: begin
        priority if (found) begin
          unique case (func_q)
            FN_ADD: begin
              mem_we    = 1'b1;
              mem_waddr = chk;
              mem_wdata = handle_q;
              ok_next   = 1'b1;
            end
            FN_REM_VAL: tgt_next = chk;
            default: begin
              iout_next = IOUT_W'(chk);
              ok_next   = 1'b1;
            end
          endcase
        end else if (ptr_lt_used) begin
          mem_raddr = AW'(ptr);
          chk_next  = AW'(ptr);
          ptr_next  = ptr + UW'(1);
          pend_next = 1'b1;
        end else if (func_q == FN_ADD) begin
          frag_next = 1'b0;
          app_req   = 1'b1;
        end else begin
          ok_next = 1'b0;
        end
      end
      ST_REMOVE: begin
        mem_we    = 1'b1;
        mem_waddr = tgt;
        ok_next   = 1'b1;
        if (tgt_is_last) begin
          used_next = used_m1;
        end else begin
          frag_next = 1'b1;
        end
      end
      ST_READ: begin
        hout_next = mem_rdata;
        ok_next   = 1'b1;
        if (func_q == FN_POP) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(used_m1);
          used_next = used_m1;
        end
      end
      ST_TRIM_RD: mem_raddr = AW'(used_m1);
      ST_TRIM_CK: begin
        if (rd_zero) used_next = used_m1;
      end
      ST_DONE: ok_next = ok;
    endcase
    if (app_req && can_app) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(used);
      mem_wdata = handle_q;
      used_next = used + UW'(1);
      ok_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cap   <= CAP_RESET;
      used  <= '0;
      frag  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      frag  <= frag_next;
      pend  <= pend_next;
      if (cfg_we) cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    func_q   <= func_q_next;
    handle_q <= handle_q_next;
    idx_q    <= idx_q_next;
    ptr      <= ptr_next;
    chk      <= chk_next;
    tgt      <= tgt_next;
    ok       <= ok_next;
    hout     <= hout_next;
    iout     <= iout_next;
  end

endmodule

// File: hw/rtl/sth_oreg.sv
// Output register that holds one finished result until it is taken.
// Depends on sth_pkg for the result type.
module sth_oreg
  import sth_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_ready,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic vld;

  assign res_ready = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (res_ready) begin
      vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res <= res;
  end

endmodule

// File: hw/rtl/sth_chk.sv
// Port-level checker for the slot table top level, attached by bind.
// Depends on sth_pkg and slot_table_with_holes_top_macros.svh.
`include "slot_table_with_holes_top_macros.svh"

module sth_chk
  import sth_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                status,
  input logic [HANDLE_W-1:0] handle_out,
  input logic [IOUT_W-1:0]   index_out,
  input logic [USED_W-1:0]   used_out
);

  `STH_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !out_valid && in_ready, "not idle after reset")

  `STH_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second item taken while busy")

  `STH_ASSERT_IMP(a_fail_clean, clk, rst, out_valid && status, (handle_out == '0) && (index_out == '0), "failed result carries data")

  `STH_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(handle_out) && $stable(used_out), "stalled result changed")

endmodule

bind slot_table_with_holes_top sth_chk u_chk (.*);
